FILE: rtl/tss_pkg.sv
// shared types, constants and helpers for the tableau simplex solver
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

    // default sizes of the tableau store
    localparam int MAX_VARS_DEF = 16;
    localparam int MAX_EQS_DEF  = 16;

    // register reset values
    localparam logic [4:0] NUM_VARS_RST   = 5'd16;
    localparam logic [4:0] NUM_EQS_RST    = 5'd16;
    localparam logic [9:0] MAX_PIVOTS_RST = 10'd256;

    // q16.16 one
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // input item codes
    localparam logic [1:0] MODE_COEF_A = 2'd0;
    localparam logic [1:0] MODE_COEF_C = 2'd1;
    localparam logic [1:0] MODE_COEF_B = 2'd2;
    localparam logic [1:0] MODE_START  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_VARS   = 2'd0;
    localparam logic [1:0] CFG_NUM_EQS    = 2'd1;
    localparam logic [1:0] CFG_MAX_PIVOTS = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [3:0]         var_index;
        logic signed [31:0] var_value;
        logic signed [31:0] objective;
        logic               last;
    } out_item_t;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tss_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/tss_div.sv
// iterative q16.16 divider, one quotient bit per cycle, positive divisor
`timescale 1ns / 1ps
`default_nettype none
module tss_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tss_pkg::div_req_t req,
    output tss_pkg::div_rsp_t      rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [31:0] rem_reg;
    logic [47:0] num_reg;
    logic [47:0] quo_reg;
    logic [31:0] den_reg;

    logic [31:0] mag;
    logic [32:0] trial;
    logic        fits;

    // magnitude of the dividend and trial subtract
    always_comb
    begin
        mag   = req.num[31] ? (~req.num + 32'd1) : req.num;
        trial = {rem_reg, num_reg[47]};
        fits  = (trial >= {1'b0, den_reg});
    end

    // shift and subtract loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= req.num[31];
                rem_reg  <= '0;
                num_reg  <= {mag, 16'd0};
                quo_reg  <= '0;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                num_reg <= {num_reg[46:0], 1'b0};
                quo_reg <= {quo_reg[46:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg)
            rsp.quo = (quo_reg > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                     : (~quo_reg[31:0] + 32'd1);
        else
            rsp.quo = (quo_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_reg[31:0];
    end

endmodule
`default_nettype wire

FILE: rtl/tableau_simplex_solver.sv
// tableau simplex solver: coefficient load, tableau build, pivots, result readout
// load requests are accepted only while idle; a start request builds the tableau with a
// coefficient read and a tableau write per word, then each pivot divides the right-hand
// side of each qualifying row, normalizes the pivot-row words through the bit-serial
// divider and eliminates the other rows; readout scans the tableau rows per variable.
// asynchronous active-low reset clears the sequencer, configuration registers and
// handshakes; tableau and coefficient rams are not cleared
`timescale 1ns / 1ps
`default_nettype none
module tableau_simplex_solver #(
    parameter int MAX_VARS = tss_pkg::MAX_VARS_DEF,
    parameter int MAX_EQS  = tss_pkg::MAX_EQS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire tss_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output tss_pkg::out_item_t      result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [9:0]         cfg_data
);

    localparam int TW  = MAX_VARS + MAX_EQS + 2;
    localparam int TD  = (MAX_EQS + 1) * TW;
    localparam int TAW = $clog2(TD);
    localparam int CD  = MAX_EQS * MAX_VARS + MAX_VARS + MAX_EQS;
    localparam int CAW = $clog2(CD);
    localparam int CW  = $clog2(TW);
    localparam int RW  = $clog2(MAX_EQS + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_BLD_RD, S_BLD_WR,
        S_CS_RD, S_CS_CHK,
        S_RS_RDV, S_RS_RDB, S_RS_CHK, S_RS_DIV,
        S_PCNT, S_PV_RD, S_PV_LAT,
        S_NR_RD, S_NR_ST, S_NR_WT,
        S_EL_F, S_EL_FL, S_EL_RA, S_EL_RB, S_EL_MUL, S_EL_SH, S_EL_WR,
        S_OB_RD, S_OB_LAT, S_OU_RD, S_OU_CHK, S_OU_RDX, S_OU_LX,
        S_EMIT, S_FAIL
    } state_t;

    typedef enum logic [1:0] {
        K_ZERO, K_ONE, K_COEF, K_NEGC
    } kind_t;

    state_t state_reg;
    kind_t  kind_reg;
    kind_t  kind;

    logic [4:0] num_vars_reg;
    logic [4:0] num_eqs_reg;
    logic [9:0] max_pivots_reg;

    logic [CW-1:0] n_reg;
    logic [RW-1:0] m_reg;
    logic [CW-1:0] wl_reg;
    logic [CW-1:0] cs_last_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [CW-1:0] pc_reg;
    logic [RW-1:0] pr_reg;
    logic [RW-1:0] xr_reg;
    logic [9:0]    pcnt_reg;
    logic          have_reg;
    logic          first_reg;
    logic          unit_reg;
    logic          seen_reg;

    logic signed [31:0] min_reg;
    logic signed [31:0] minr_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mq_reg;
    logic signed [31:0] obj_reg;
    logic signed [31:0] xv_reg;

    logic                result_valid_reg;
    tss_pkg::out_item_t  result_reg;

    logic [CW-1:0] n_cl;
    logic [RW-1:0] m_cl;
    logic [9:0]    pcnt_next;
    logic          out_free;

    logic           tab_we;
    logic [TAW-1:0] tab_waddr;
    logic [31:0]    tab_wdata;
    logic [TAW-1:0] tab_raddr;
    logic [31:0]    tab_rdata;
    logic           coef_we;
    logic [CAW-1:0] coef_waddr;
    logic [CAW-1:0] coef_raddr;
    logic [31:0]    coef_rdata;

    tss_pkg::div_req_t div_req;
    tss_pkg::div_rsp_t div_rsp;

    logic signed [47:0] sh;
    logic signed [32:0] sum;

    function automatic logic [TAW-1:0] taddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return TAW'(int'(r) * TW + int'(c));
    endfunction

    tss_ram #(.WIDTH(32), .DEPTH(TD)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    tss_ram #(.WIDTH(32), .DEPTH(CD)) u_coef (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (item.value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    tss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;
    assign pcnt_next    = pcnt_reg + 10'd1;

    // clamped problem size
    always_comb
    begin
        if (num_vars_reg == 5'd0)
            n_cl = CW'(1);
        else if (int'(num_vars_reg) > MAX_VARS)
            n_cl = CW'(MAX_VARS);
        else
            n_cl = CW'(num_vars_reg);
        if (num_eqs_reg == 5'd0)
            m_cl = RW'(1);
        else if (int'(num_eqs_reg) > MAX_EQS)
            m_cl = RW'(MAX_EQS);
        else
            m_cl = RW'(num_eqs_reg);
    end

    // coefficient load writes
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = '0;
        if (item_valid && item_ready)
        begin
            case (item.mode)
                tss_pkg::MODE_COEF_A:
                begin
                    coef_we    = (int'(item.row) < MAX_EQS) && (int'(item.col) < MAX_VARS);
                    coef_waddr = CAW'(int'(item.row) * MAX_VARS + int'(item.col));
                end
                tss_pkg::MODE_COEF_C:
                begin
                    coef_we    = (int'(item.col) < MAX_VARS);
                    coef_waddr = CAW'(MAX_EQS * MAX_VARS + int'(item.col));
                end
                tss_pkg::MODE_COEF_B:
                begin
                    coef_we    = (int'(item.row) < MAX_EQS);
                    coef_waddr = CAW'(MAX_EQS * MAX_VARS + MAX_VARS + int'(item.row));
                end
                default:
                begin
                    coef_we = 1'b0;
                end
            endcase
        end
    end

    // build: kind of each tableau word and its coefficient address
    always_comb
    begin
        kind       = K_ZERO;
        coef_raddr = '0;
        if (r_reg < m_reg)
        begin
            if (c_reg < n_reg)
            begin
                kind       = K_COEF;
                coef_raddr = CAW'(int'(r_reg) * MAX_VARS + int'(c_reg));
            end
            else if (c_reg == n_reg + CW'(r_reg))
                kind = K_ONE;
            else if (c_reg == wl_reg)
            begin
                kind       = K_COEF;
                coef_raddr = CAW'(MAX_EQS * MAX_VARS + MAX_VARS + int'(r_reg));
            end
        end
        else
        begin
            if (c_reg < n_reg)
            begin
                kind       = K_NEGC;
                coef_raddr = CAW'(MAX_EQS * MAX_VARS + int'(c_reg));
            end
            else if (c_reg == n_reg + CW'(m_reg))
                kind = K_ONE;
        end
    end

    // elimination arithmetic
    always_comb
    begin
        sh = prod_reg[63:16];
        if (prod_reg[63] && (prod_reg[15:0] != 16'd0))
            sh = sh + 48'sd1;
        sum = {mq_reg[31], mq_reg} + {b_reg[31], b_reg};
    end

    // tableau port and divider requests per state
    always_comb
    begin
        tab_we      = 1'b0;
        tab_waddr   = taddr(r_reg, c_reg);
        tab_wdata   = '0;
        tab_raddr   = taddr(r_reg, c_reg);
        div_req     = '0;
        case (state_reg)
            S_BLD_WR:
            begin
                tab_we = 1'b1;
                case (kind_reg)
                    K_ONE:   tab_wdata = tss_pkg::Q_ONE;
                    K_COEF:  tab_wdata = coef_rdata;
                    K_NEGC:  tab_wdata = tss_pkg::sat32(-{{32{coef_rdata[31]}}, coef_rdata});
                    default: tab_wdata = '0;
                endcase
            end
            S_CS_RD:  tab_raddr = taddr(m_reg, c_reg);
            S_RS_RDV: tab_raddr = taddr(r_reg, pc_reg);
            S_RS_RDB: tab_raddr = taddr(r_reg, wl_reg);
            S_RS_CHK:
            begin
                div_req.start = (v_reg > 32'sd0) && !tab_rdata[31];
                div_req.num   = tab_rdata;
                div_req.den   = v_reg;
            end
            S_PV_RD:  tab_raddr = taddr(pr_reg, pc_reg);
            S_NR_RD:  tab_raddr = taddr(pr_reg, c_reg);
            S_NR_ST:
            begin
                div_req.start = 1'b1;
                div_req.num   = tab_rdata;
                div_req.den   = p_reg;
            end
            S_NR_WT:
            begin
                tab_we    = div_rsp.done;
                tab_waddr = taddr(pr_reg, c_reg);
                tab_wdata = div_rsp.quo;
            end
            S_EL_F:   tab_raddr = taddr(r_reg, pc_reg);
            S_EL_RA:  tab_raddr = taddr(pr_reg, c_reg);
            S_EL_RB:  tab_raddr = taddr(r_reg, c_reg);
            S_EL_WR:
            begin
                tab_we    = 1'b1;
                tab_wdata = tss_pkg::sat32({{31{sum[32]}}, sum});
            end
            S_OB_RD:  tab_raddr = taddr(m_reg, wl_reg);
            S_OU_RD:  tab_raddr = taddr(r_reg, c_reg);
            S_OU_RDX: tab_raddr = taddr(xr_reg, wl_reg);
            default:
            begin
                tab_we = 1'b0;
            end
        endcase
    end

    // sequencer, registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_vars_reg     <= tss_pkg::NUM_VARS_RST;
            num_eqs_reg      <= tss_pkg::NUM_EQS_RST;
            max_pivots_reg   <= tss_pkg::MAX_PIVOTS_RST;
            pcnt_reg         <= '0;
            pc_reg           <= '0;
            pr_reg           <= '0;
            r_reg            <= '0;
            c_reg            <= '0;
            have_reg         <= 1'b0;
            first_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    tss_pkg::CFG_NUM_VARS:   num_vars_reg   <= cfg_data[4:0];
                    tss_pkg::CFG_NUM_EQS:    num_eqs_reg    <= cfg_data[4:0];
                    tss_pkg::CFG_MAX_PIVOTS: max_pivots_reg <= cfg_data;
                    default:                 ;
                endcase
            end

            // result drained and no new result loaded this cycle
            if (result_ready &&
                !(out_free && (state_reg == S_EMIT || state_reg == S_FAIL)))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid && item.mode == tss_pkg::MODE_START)
                    begin
                        n_reg       <= n_cl;
                        m_reg       <= m_cl;
                        wl_reg      <= n_cl + CW'(m_cl) + CW'(1);
                        cs_last_reg <= n_cl + CW'(m_cl) - CW'(1);
                        pcnt_reg    <= '0;
                        r_reg       <= '0;
                        c_reg       <= '0;
                        state_reg   <= S_BLD_RD;
                    end
                end
                // tableau build
                S_BLD_RD:
                begin
                    kind_reg  <= kind;
                    state_reg <= S_BLD_WR;
                end
                S_BLD_WR:
                begin
                    if (c_reg == wl_reg)
                    begin
                        c_reg <= '0;
                        if (r_reg == m_reg)
                        begin
                            min_reg   <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= S_CS_RD;
                        end
                        else
                        begin
                            r_reg     <= r_reg + RW'(1);
                            state_reg <= S_BLD_RD;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_BLD_RD;
                    end
                end
                // entering column scan
                S_CS_RD:
                begin
                    state_reg <= S_CS_CHK;
                end
                S_CS_CHK:
                begin
                    if ($signed(tab_rdata) < min_reg)
                    begin
                        min_reg  <= tab_rdata;
                        pc_reg   <= c_reg;
                        have_reg <= 1'b1;
                    end
                    if (c_reg == cs_last_reg)
                    begin
                        if (have_reg || ($signed(tab_rdata) < min_reg))
                        begin
                            r_reg     <= '0;
                            first_reg <= 1'b1;
                            state_reg <= S_RS_RDV;
                        end
                        else
                            state_reg <= S_OB_RD;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_CS_RD;
                    end
                end
                // leaving row ratio test
                S_RS_RDV:
                begin
                    state_reg <= S_RS_RDB;
                end
                S_RS_RDB:
                begin
                    v_reg     <= tab_rdata;
                    state_reg <= S_RS_CHK;
                end
                S_RS_CHK, S_RS_DIV:
                begin
                    if (state_reg == S_RS_CHK && div_req.start)
                        state_reg <= S_RS_DIV;
                    else if (state_reg == S_RS_DIV && !div_rsp.done)
                        state_reg <= S_RS_DIV;
                    else
                    begin
                        if (state_reg == S_RS_DIV && (first_reg || div_rsp.quo < minr_reg))
                        begin
                            minr_reg  <= div_rsp.quo;
                            pr_reg    <= r_reg;
                            first_reg <= 1'b0;
                        end
                        if (r_reg == m_reg - RW'(1))
                        begin
                            if (first_reg && !(state_reg == S_RS_DIV))
                                state_reg <= S_FAIL;
                            else
                                state_reg <= S_PCNT;
                        end
                        else
                        begin
                            r_reg     <= r_reg + RW'(1);
                            state_reg <= S_RS_RDV;
                        end
                    end
                end
                // pivot limit
                S_PCNT:
                begin
                    if (first_reg)
                        state_reg <= S_FAIL;
                    else
                    begin
                        pcnt_reg <= pcnt_next;
                        if (pcnt_next == max_pivots_reg)
                            state_reg <= S_FAIL;
                        else
                            state_reg <= S_PV_RD;
                    end
                end
                S_PV_RD:
                begin
                    state_reg <= S_PV_LAT;
                end
                S_PV_LAT:
                begin
                    p_reg     <= tab_rdata;
                    c_reg     <= '0;
                    state_reg <= S_NR_RD;
                end
                // pivot row normalization
                S_NR_RD:
                begin
                    state_reg <= S_NR_ST;
                end
                S_NR_ST:
                begin
                    state_reg <= S_NR_WT;
                end
                S_NR_WT:
                begin
                    if (div_rsp.done)
                    begin
                        if (c_reg == wl_reg)
                        begin
                            r_reg     <= '0;
                            state_reg <= S_EL_F;
                        end
                        else
                        begin
                            c_reg     <= c_reg + CW'(1);
                            state_reg <= S_NR_RD;
                        end
                    end
                end
                // elimination of the other rows
                S_EL_F:
                begin
                    if (r_reg == pr_reg)
                    begin
                        if (r_reg == m_reg)
                        begin
                            c_reg     <= '0;
                            min_reg   <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= S_CS_RD;
                        end
                        else
                            r_reg <= r_reg + RW'(1);
                    end
                    else
                        state_reg <= S_EL_FL;
                end
                S_EL_FL:
                begin
                    f_reg     <= tss_pkg::sat32(-{{32{tab_rdata[31]}}, tab_rdata});
                    c_reg     <= '0;
                    state_reg <= S_EL_RA;
                end
                S_EL_RA:
                begin
                    state_reg <= S_EL_RB;
                end
                S_EL_RB:
                begin
                    a_reg     <= tab_rdata;
                    state_reg <= S_EL_MUL;
                end
                S_EL_MUL:
                begin
                    b_reg     <= tab_rdata;
                    prod_reg  <= a_reg * f_reg;
                    state_reg <= S_EL_SH;
                end
                S_EL_SH:
                begin
                    mq_reg    <= tss_pkg::sat32({{16{sh[47]}}, sh});
                    state_reg <= S_EL_WR;
                end
                S_EL_WR:
                begin
                    if (c_reg == wl_reg)
                    begin
                        if (r_reg == m_reg)
                        begin
                            c_reg     <= '0;
                            min_reg   <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= S_CS_RD;
                        end
                        else
                        begin
                            r_reg     <= r_reg + RW'(1);
                            state_reg <= S_EL_F;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_EL_RA;
                    end
                end
                // objective and per-variable readout
                S_OB_RD:
                begin
                    state_reg <= S_OB_LAT;
                end
                S_OB_LAT:
                begin
                    obj_reg   <= tab_rdata;
                    c_reg     <= '0;
                    r_reg     <= '0;
                    unit_reg  <= 1'b1;
                    seen_reg  <= 1'b0;
                    state_reg <= S_OU_RD;
                end
                S_OU_RD:
                begin
                    state_reg <= S_OU_CHK;
                end
                S_OU_CHK:
                begin
                    if (tab_rdata == tss_pkg::Q_ONE && !seen_reg)
                    begin
                        seen_reg <= 1'b1;
                        xr_reg   <= r_reg;
                    end
                    else if (tab_rdata != 32'd0)
                        unit_reg <= 1'b0;
                    if (r_reg == m_reg)
                    begin
                        if (unit_reg && (tab_rdata == 32'd0 ||
                            (tab_rdata == tss_pkg::Q_ONE && !seen_reg)) &&
                            (seen_reg || tab_rdata == tss_pkg::Q_ONE))
                            state_reg <= S_OU_RDX;
                        else
                        begin
                            xv_reg    <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        r_reg     <= r_reg + RW'(1);
                        state_reg <= S_OU_RD;
                    end
                end
                S_OU_RDX:
                begin
                    state_reg <= S_OU_LX;
                end
                S_OU_LX:
                begin
                    xv_reg    <= tab_rdata;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg     <= 1'b1;
                        result_reg.status    <= 1'b0;
                        result_reg.var_index <= 4'(c_reg);
                        result_reg.var_value <= xv_reg;
                        result_reg.objective <= obj_reg;
                        result_reg.last      <= (c_reg == n_reg - CW'(1));
                        if (c_reg == n_reg - CW'(1))
                            state_reg <= S_IDLE;
                        else
                        begin
                            c_reg     <= c_reg + CW'(1);
                            r_reg     <= '0;
                            unit_reg  <= 1'b1;
                            seen_reg  <= 1'b0;
                            state_reg <= S_OU_RD;
                        end
                    end
                end
                // no solution result
                S_FAIL:
                begin
                    if (out_free)
                    begin
                        result_valid_reg     <= 1'b1;
                        result_reg.status    <= 1'b1;
                        result_reg.var_index <= '0;
                        result_reg.var_value <= '0;
                        result_reg.objective <= '0;
                        result_reg.last      <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/tb_tableau_simplex_solver.sv
// testbench for the tableau simplex solver: directed and random linear programs
`timescale 1ns / 1ps
module tb_tableau_simplex_solver;

    localparam int NV       = 16;
    localparam int NE       = 16;
    localparam int TCOLS    = NV + NE + 2;
    localparam int SETTLE   = 40;
    localparam int LIMIT    = 50000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    tss_pkg::in_item_t  item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    tss_pkg::out_item_t result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    // solver model state
    int         coef_a [NE][NV];
    int         coef_c [NV];
    int         coef_b [NE];
    int         tab [NE+1][TCOLS];
    logic [4:0] model_nv = tss_pkg::NUM_VARS_RST;
    logic [4:0] model_ne = tss_pkg::NUM_EQS_RST;
    logic [9:0] model_maxp = tss_pkg::MAX_PIVOTS_RST;

    // stimulus bookkeeping
    bit         set_a [NE][NV];
    bit         set_c [NV];
    bit         set_b [NE];
    int         cur_n = 16;
    int         cur_m = 16;
    int         pushed = 0;

    tss_pkg::in_item_t  request_q [$];
    tss_pkg::out_item_t solution_q [$];
    int         accepted = 0;
    int         errors = 0;
    int         cycles = 0;
    bit         req_taken = 1'b0;

    tableau_simplex_solver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // q16.16 helpers
    function automatic int sat(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int mulq(int a, int b);
        return sat((longint'(a) * longint'(b)) / 65536);
    endfunction

    function automatic int divq(int a, int p);
        return sat((longint'(a) * 65536) / longint'(p));
    endfunction

    function automatic int clamp_size(logic [4:0] v);
        if (v < 1)
            return 1;
        return (v > 16) ? 16 : int'(v);
    endfunction

    // apply one request to the model and queue the solutions it yields
    function automatic void predict_request(tss_pkg::in_item_t rq);
        int n, m, w, r, c, minv, minr, q, rhs, v, p, f, xv, obj;
        int pcol, prow;
        logic [9:0] pcount;
        bit have, first, unit, seen, done, optimal;
        tss_pkg::out_item_t o;
        case (rq.mode)
            tss_pkg::MODE_COEF_A: coef_a[rq.row][rq.col] = rq.value;
            tss_pkg::MODE_COEF_C: coef_c[rq.col] = rq.value;
            tss_pkg::MODE_COEF_B: coef_b[rq.row] = rq.value;
            default:
            begin
                n = clamp_size(model_nv);
                m = clamp_size(model_ne);
                w = n + m + 2;
                for (r = 0; r <= NE; r++)
                    for (c = 0; c < TCOLS; c++)
                        tab[r][c] = 0;
                for (r = 0; r < m; r++)
                begin
                    for (c = 0; c < n; c++)
                        tab[r][c] = coef_a[r][c];
                    tab[r][n+r] = 32'sh0001_0000;
                    tab[r][w-1] = coef_b[r];
                end
                for (c = 0; c < n; c++)
                    tab[m][c] = sat(-longint'(coef_c[c]));
                tab[m][n+m] = 32'sh0001_0000;
                pcount = '0;
                pcol = 0;
                prow = 0;
                done = 1'b0;
                optimal = 1'b0;
                while (!done)
                begin
                    // entering column: most negative objective entry
                    minv = 0;
                    have = 1'b0;
                    for (c = 0; c + 2 < w; c++)
                        if (tab[m][c] < minv)
                        begin
                            minv = tab[m][c];
                            pcol = c;
                            have = 1'b1;
                        end
                    if (!have)
                    begin
                        optimal = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        // leaving row: smallest nonnegative ratio
                        first = 1'b1;
                        minr = 0;
                        for (r = 0; r < m; r++)
                        begin
                            v = tab[r][pcol];
                            if (v > 0)
                            begin
                                rhs = tab[r][w-1];
                                q = divq(rhs, v);
                                if (rhs >= 0 && (first || q < minr))
                                begin
                                    minr = q;
                                    prow = r;
                                    first = 1'b0;
                                end
                            end
                        end
                        pcount = pcount + 10'd1;
                        if (first || pcount == model_maxp)
                            done = 1'b1;
                        else
                        begin
                            p = tab[prow][pcol];
                            for (c = 0; c < w; c++)
                                tab[prow][c] = divq(tab[prow][c], p);
                            for (r = 0; r <= m; r++)
                                if (r != prow)
                                begin
                                    f = sat(-longint'(tab[r][pcol]));
                                    for (c = 0; c < w; c++)
                                        tab[r][c] = sat(longint'(mulq(tab[prow][c], f))
                                                        + longint'(tab[r][c]));
                                end
                        end
                    end
                end
                if (!optimal)
                begin
                    o = '0;
                    o.status = 1'b1;
                    o.last = 1'b1;
                    solution_q = {solution_q, o};
                end
                else
                begin
                    obj = tab[m][w-1];
                    for (c = 0; c < n; c++)
                    begin
                        unit = 1'b1;
                        seen = 1'b0;
                        xv = 0;
                        for (r = 0; r <= m; r++)
                        begin
                            if (tab[r][c] == 32'sh0001_0000 && !seen)
                            begin
                                seen = 1'b1;
                                xv = tab[r][w-1];
                            end
                            else if (tab[r][c] != 0)
                                unit = 1'b0;
                        end
                        o.status = 1'b0;
                        o.var_index = c[3:0];
                        o.var_value = (unit && seen) ? xv : 0;
                        o.objective = obj;
                        o.last = (c + 1 == n);
                        solution_q = {solution_q, o};
                    end
                end
            end
        endcase
    endfunction

    // idle percentages per phase of the run
    function automatic int send_idle_pct();
        return (accepted < 90) ? 7 : (accepted < 180) ? 59 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (accepted < 90) ? 59 : (accepted < 180) ? 7 : 0;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || req_taken))
        begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct())
            begin
                item_valid <= 1'b1;
                item <= request_q.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
        req_taken = 1'b0;
        result_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct());
    end

    // request and result monitor
    always @(posedge clk)
    begin
        tss_pkg::out_item_t e;
        if (rst_n && item_valid && item_ready)
        begin
            req_taken = 1'b1;
            accepted++;
            predict_request(item);
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (solution_q.size() == 0)
            begin
                $error("unexpected result %p", result);
                errors++;
            end
            else
            begin
                e = solution_q.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status exp %0h got %0h", e.status, result.status);
                    errors++;
                end
                if (result.var_index !== e.var_index)
                begin
                    $error("var_index exp %0h got %0h", e.var_index, result.var_index);
                    errors++;
                end
                if (result.var_value !== e.var_value)
                begin
                    $error("var_value exp %0h got %0h", e.var_value, result.var_value);
                    errors++;
                end
                if (result.objective !== e.objective)
                begin
                    $error("objective exp %0h got %0h", e.objective, result.objective);
                    errors++;
                end
                if (result.last !== e.last)
                begin
                    $error("last exp %0h got %0h", e.last, result.last);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // wait until the block has drained every request and result
    task automatic settle();
        wait (request_q.size() == 0 && !item_valid && solution_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tss_pkg::CFG_NUM_VARS:
            begin
                model_nv = data[4:0];
                cur_n = clamp_size(data[4:0]);
            end
            tss_pkg::CFG_NUM_EQS:
            begin
                model_ne = data[4:0];
                cur_m = clamp_size(data[4:0]);
            end
            default: model_maxp = data;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(int nv, int ne, int maxp);
        settle();
        write_reg(tss_pkg::CFG_NUM_VARS, nv[9:0]);
        write_reg(tss_pkg::CFG_NUM_EQS, ne[9:0]);
        write_reg(tss_pkg::CFG_MAX_PIVOTS, maxp[9:0]);
    endtask

    task automatic push(logic [1:0] mode, int row, int col, int val);
        tss_pkg::in_item_t rq;
        rq.mode = mode;
        rq.row = row[3:0];
        rq.col = col[3:0];
        rq.value = val;
        if (mode == tss_pkg::MODE_COEF_A)
            set_a[row][col] = 1'b1;
        if (mode == tss_pkg::MODE_COEF_C)
            set_c[col] = 1'b1;
        if (mode == tss_pkg::MODE_COEF_B)
            set_b[row] = 1'b1;
        request_q = {request_q, rq};
        pushed++;
    endtask

    task automatic start_solve();
        push(tss_pkg::MODE_START, $urandom_range(15), $urandom_range(15), $urandom);
    endtask

    // random program: well-formed bounded content, or raw noise
    task automatic random_program(bit noise);
        int r, c, v;
        for (r = 0; r < cur_m; r++)
        begin
            for (c = 0; c < cur_n; c++)
                if (!set_a[r][c] || $urandom_range(2) != 0)
                begin
                    v = noise ? $urandom : ($urandom_range(3) == 0 ? 0
                                            : $urandom_range(262144));
                    push(tss_pkg::MODE_COEF_A, r, c, v);
                end
            if (!set_b[r] || $urandom_range(1) == 0)
            begin
                v = noise ? $urandom : $urandom_range(1310720);
                push(tss_pkg::MODE_COEF_B, r, 0, v);
            end
        end
        for (c = 0; c < cur_n; c++)
            if (!set_c[c] || $urandom_range(1) == 0)
            begin
                v = noise ? $urandom : $urandom_range(327680);
                if (!noise && $urandom_range(4) == 0)
                    v = -v;
                push(tss_pkg::MODE_COEF_C, 0, c, v);
            end
        start_solve();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // textbook program with a known optimum
        set_sizes(2, 3, 256);
        push(tss_pkg::MODE_COEF_A, 0, 0, 32'sh0001_0000);
        push(tss_pkg::MODE_COEF_A, 0, 1, 0);
        push(tss_pkg::MODE_COEF_A, 1, 0, 0);
        push(tss_pkg::MODE_COEF_A, 1, 1, 32'sh0002_0000);
        push(tss_pkg::MODE_COEF_A, 2, 0, 32'sh0003_0000);
        push(tss_pkg::MODE_COEF_A, 2, 1, 32'sh0002_0000);
        push(tss_pkg::MODE_COEF_B, 0, 0, 32'sh0004_0000);
        push(tss_pkg::MODE_COEF_B, 1, 0, 32'sh000C_0000);
        push(tss_pkg::MODE_COEF_B, 2, 0, 32'sh0012_0000);
        push(tss_pkg::MODE_COEF_C, 0, 0, 32'sh0003_0000);
        push(tss_pkg::MODE_COEF_C, 0, 1, 32'sh0005_0000);
        start_solve();

        // pivot limit on the first pivot
        set_sizes(2, 3, 1);
        start_solve();

        // unbounded, size zero clamped to one
        set_sizes(0, 1, 1023);
        push(tss_pkg::MODE_COEF_A, 0, 0, -32'sh0001_0000);
        push(tss_pkg::MODE_COEF_B, 0, 0, 32'sh0001_0000);
        push(tss_pkg::MODE_COEF_C, 0, 0, 32'sh0001_0000);
        start_solve();

        // extreme values, negative right-hand side
        push(tss_pkg::MODE_COEF_A, 0, 0, 32'sh7FFF_FFFF);
        push(tss_pkg::MODE_COEF_B, 0, 0, -32'sh0001_0000);
        push(tss_pkg::MODE_COEF_C, 0, 0, 32'sh7FFF_FFFF);
        start_solve();
        push(tss_pkg::MODE_COEF_B, 0, 0, 32'sh7FFF_FFFF);
        push(tss_pkg::MODE_COEF_C, 0, 0, 32'sh8000_0000);
        start_solve();
        push(tss_pkg::MODE_COEF_C, 0, 0, 32'sh0000_0001);
        start_solve();

        // random programs in phases of random sizes
        while (pushed < 140)
        begin
            set_sizes($urandom_range(5), $urandom_range(5),
                      ($urandom_range(7) == 0) ? 1023 : $urandom_range(1, 40));
            repeat ($urandom_range(2, 4))
                random_program($urandom_range(5) == 0);
        end

        // widest program with a tight pivot limit
        set_sizes(31, 4, 3);
        random_program(1'b0);

        // deepest program with a tight pivot limit
        set_sizes(2, 16, 3);
        random_program(1'b0);

        settle();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
